### rtl/pfpe_pkg.sv
// Shared constants and types of the page framebuffer pixel engine.
`default_nettype none
package pfpe_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  localparam int PAGE_ROWS = 8;
  localparam int PAGE_W    = 5;

  typedef logic [1:0] mode_t;
  typedef logic [7:0] byte_t;

  localparam mode_t MODE_PIXEL   = 2'd0;
  localparam mode_t MODE_PATTERN = 2'd1;
  localparam mode_t MODE_READ    = 2'd2;
  localparam mode_t MODE_CLEAR   = 2'd3;

  localparam logic [2:0] ROW_IN_PAGE = 3'b111;

endpackage
`default_nettype wire

### rtl/page_framebuffer_pixel_engine_unit.sv
// Top level of the page framebuffer pixel engine: page store, merge sequencer, clear walk.
`default_nettype none
// The image sits in one simple dual-port synchronous memory of PAGE_COUNT * PANEL_WIDTH bytes
// (1024 at 128x64), one byte per column of a page, bit 0 the top row of the page. A beat is
// taken while start is high and busy is low. A read, a pixel write and a pattern write that
// stays in one page pass from idle through S_PIX or S_MOD; a pattern that spills into the next
// page goes on through S_MOD2; an out-of-panel read or write leaves the block idle. A written
// byte is read and then written back in the following cycle. A read beat returns its pixel on
// out_pixel with out_valid high for exactly one cycle, via rd_data_r and out_pixel_r (in the
// cycle after acceptance when out of panel); the receiver cannot stall it. After reset and
// every clear beat the block walks the memory one byte per cycle, busy until all are clear.
module page_framebuffer_pixel_engine_unit
  import pfpe_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] in_mode,
  input  wire  [7:0] in_x,
  input  wire  [7:0] in_y,
  input  wire  [7:0] in_pattern,
  input  wire        in_set_bit,
  output logic       out_valid,
  output logic       out_pixel
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = PAGE_COUNT * PANEL_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LAST_ROWS   = PANEL_HEIGHT % PAGE_ROWS;
  localparam byte_t LAST_MASK = (LAST_ROWS == 0) ? 8'hFF : 8'((1 << LAST_ROWS) - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PIX  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_MOD2 = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_idx_r;
  logic [ADDR_W-1:0] addr1_r, addr2_r;
  byte_t             mask1_r, mask2_r;
  logic              spill_r, set_r;
  logic [2:0]        bit_r;
  logic              out_valid_r, out_pixel_r;

  byte_t             mem [STORE_BYTES];
  byte_t             rd_data_r;

  logic              accept;
  logic              on_panel;
  logic [PAGE_W-1:0] page_in;
  logic [2:0]        bit_in;
  logic [ADDR_W-1:0] addr_in, addr_next_page, rd_addr, wr_addr;
  logic [15:0]       shifted;
  byte_t             page_mask, next_mask, m1, m2, wr_data;
  logic              spill_in, wr_en;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign page_in  = in_y[7:3];
  assign bit_in   = in_y[2:0] & ROW_IN_PAGE;
  assign on_panel = ({1'b0, in_x} < 9'(PANEL_WIDTH)) && ({1'b0, in_y} < 9'(PANEL_HEIGHT));

  assign addr_in        = ADDR_W'(page_in * PANEL_WIDTH + in_x);
  assign addr_next_page = ADDR_W'((page_in + 1) * PANEL_WIDTH + in_x);
  assign shifted        = {8'h00, in_pattern} << bit_in;
  assign page_mask      = (page_in == LAST_PAGE) ? LAST_MASK : 8'hFF;
  assign next_mask      = ((page_in + 1'b1) == LAST_PAGE) ? LAST_MASK : 8'hFF;
  assign spill_in       = (in_mode == MODE_PATTERN) && (bit_in != 3'd0) &&
                          ({1'b0, page_in} + 6'd1 < 6'(PAGE_COUNT));

  always_comb begin
    if (in_mode == MODE_PATTERN) begin
      m1 = shifted[7:0] & page_mask;
    end else begin
      m1 = (8'h01 << bit_in) & page_mask;
    end
    m2 = shifted[15:8] & next_mask;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_CLEAR: state_nxt = S_CLR;
            MODE_READ:  state_nxt = on_panel ? S_PIX : S_IDLE;
            default:    state_nxt = on_panel ? S_MOD : S_IDLE;
          endcase
        end
      end
      S_PIX:  state_nxt = S_IDLE;
      S_MOD:  state_nxt = spill_r ? S_MOD2 : S_IDLE;
      S_MOD2: state_nxt = S_IDLE;
      S_CLR:  state_nxt = (clr_idx_r == LAST_ADDR) ? S_IDLE : S_CLR;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_addr = (state_r == S_IDLE) ? addr_in : addr2_r;
  assign wr_en   = (state_r == S_MOD) || (state_r == S_MOD2) || (state_r == S_CLR);

  always_comb begin
    case (state_r)
      S_MOD: begin
        wr_addr = addr1_r;
        wr_data = set_r ? (rd_data_r | mask1_r) : (rd_data_r & ~mask1_r);
      end
      S_MOD2: begin
        wr_addr = addr2_r;
        wr_data = set_r ? (rd_data_r | mask2_r) : (rd_data_r & ~mask2_r);
      end
      default: begin
        wr_addr = clr_idx_r;
        wr_data = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == S_CLR) begin
        clr_idx_r <= (clr_idx_r == LAST_ADDR) ? '0 : clr_idx_r + 1'b1;
      end
      if (accept && (in_mode == MODE_READ) && !on_panel) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_PIX) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1_r <= addr_in;
      addr2_r <= addr_next_page;
      mask1_r <= m1;
      mask2_r <= m2;
      spill_r <= spill_in;
      set_r   <= in_set_bit;
      bit_r   <= bit_in;
    end
    if (accept && (in_mode == MODE_READ) && !on_panel) begin
      out_pixel_r <= 1'b0;
    end else if (state_r == S_PIX) begin
      out_pixel_r <= rd_data_r[bit_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

`ifndef SYNTHESIS
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_PIX || (accept && in_mode == MODE_READ)))
    else $error("result strobe without a read beat");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_idx_r != LAST_ADDR) |=>
      (state_r == S_CLR && clr_idx_r == $past(clr_idx_r) + 1'b1))
    else $error("clear walk skipped or stopped early");

  a_spill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD2) |-> $past(state_r == S_MOD && spill_r))
    else $error("second page write without a first");
`endif

endmodule
`default_nettype wire
